// File: rtl/ipv4ov_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4ov_pkg;

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [2:0] OT_SEC    = 3'd0;
    localparam logic [2:0] OT_LSRR   = 3'd1;
    localparam logic [2:0] OT_SSRR   = 3'd2;
    localparam logic [2:0] OT_RR     = 3'd3;
    localparam logic [2:0] OT_TS     = 3'd4;
    localparam logic [2:0] OT_RTRALT = 3'd5;

    localparam logic [7:0] TYPE_EOL    = 8'd0;
    localparam logic [7:0] TYPE_NOP    = 8'd1;
    localparam logic [7:0] TYPE_SEC    = 8'd130;
    localparam logic [7:0] TYPE_LSRR   = 8'd131;
    localparam logic [7:0] TYPE_SSRR   = 8'd137;
    localparam logic [7:0] TYPE_RR     = 8'd7;
    localparam logic [7:0] TYPE_TS     = 8'd68;
    localparam logic [7:0] TYPE_RTRALT = 8'd148;

    localparam logic [7:0] LEN_SEC     = 8'd11;
    localparam logic [7:0] LEN_ROUTE   = 8'd3;
    localparam logic [7:0] LEN_FIXED   = 8'd4;
    localparam logic [7:0] TS_FLAG_OFS = 8'd3;

    localparam logic [3:0] TS_FLG_ONLY  = 4'd0;
    localparam logic [3:0] TS_FLG_ADDR  = 4'd1;
    localparam logic [3:0] TS_FLG_PRESP = 4'd3;

    localparam int SEEN_W = 5;

    typedef struct packed {
        logic       step;
        logic [7:0] option_byte;
        logic       last_byte;
    } ipv4ov_word_t;

endpackage

`default_nettype wire

// File: rtl/ipv4ov_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipv4ov_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_byte;
    logic       last_byte;

    modport source (output valid, output option_byte, output last_byte, input ready);
    modport sink   (input valid, input option_byte, input last_byte, output ready);
endinterface

interface ipv4ov_out_if;
    logic valid;
    logic ready;
    logic verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// File: rtl/ipv4ov_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4ov_parse #(
    parameter int MAX_OPTION_BYTES = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ipv4ov_pkg::ipv4ov_word_t word,
    output logic                       verdict
);

    localparam int CW = $clog2(MAX_OPTION_BYTES + 2);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OPTION_BYTES);

    logic [1:0]                    ph_reg,   ph_next;
    logic [2:0]                    cur_reg,  cur_next;
    logic [7:0]                    left_reg, left_next;
    logic [7:0]                    off_reg,  off_next;
    logic [ipv4ov_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic                          inv_reg,  inv_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg,  cnt_next;

    always_comb
    begin
        logic                          known;
        logic                          ok;
        logic [2:0]                    code;
        logic [ipv4ov_pkg::SEEN_W-1:0] bit_sel;
        logic [3:0]                    flg;

        known     = 1'b0;
        ok        = 1'b0;
        code      = ipv4ov_pkg::OT_SEC;
        bit_sel   = '0;
        flg       = word.option_byte[3:0];

        ph_next   = ph_reg;
        cur_next  = cur_reg;
        left_next = left_reg;
        off_next  = off_reg;
        seen_next = seen_reg;
        inv_next  = inv_reg;
        done_next = done_reg;
        cnt_next  = (cnt_reg <= MAX_CNT) ? cnt_reg + CW'(1) : cnt_reg;
        if (cnt_next > MAX_CNT)
        begin
            inv_next = 1'b1;
        end

        if (!done_reg)
        begin
            case (ph_reg)
                ipv4ov_pkg::PH_TYPE:
                begin
                    case (word.option_byte)
                        ipv4ov_pkg::TYPE_EOL:    done_next = 1'b1;
                        ipv4ov_pkg::TYPE_NOP:    known = 1'b0;
                        ipv4ov_pkg::TYPE_SEC:    begin known = 1'b1; code = ipv4ov_pkg::OT_SEC; end
                        ipv4ov_pkg::TYPE_LSRR:   begin known = 1'b1; code = ipv4ov_pkg::OT_LSRR; end
                        ipv4ov_pkg::TYPE_SSRR:   begin known = 1'b1; code = ipv4ov_pkg::OT_SSRR; end
                        ipv4ov_pkg::TYPE_RR:     begin known = 1'b1; code = ipv4ov_pkg::OT_RR; end
                        ipv4ov_pkg::TYPE_TS:     begin known = 1'b1; code = ipv4ov_pkg::OT_TS; end
                        ipv4ov_pkg::TYPE_RTRALT: begin known = 1'b1; code = ipv4ov_pkg::OT_RTRALT; end
                        default:
                        begin
                            inv_next  = 1'b1;
                            done_next = 1'b1;
                        end
                    endcase
                    if (known)
                    begin
                        bit_sel = ipv4ov_pkg::SEEN_W'(1) << code;
                        if (code != ipv4ov_pkg::OT_RTRALT && (seen_reg & bit_sel) != '0)
                        begin
                            inv_next  = 1'b1;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            if (code != ipv4ov_pkg::OT_RTRALT)
                            begin
                                seen_next = seen_reg | bit_sel;
                            end
                            cur_next = code;
                            off_next = 8'd1;
                            ph_next  = ipv4ov_pkg::PH_LEN;
                        end
                    end
                end
                ipv4ov_pkg::PH_LEN:
                begin
                    case (cur_reg)
                        ipv4ov_pkg::OT_SEC:  ok = (word.option_byte == ipv4ov_pkg::LEN_SEC);
                        ipv4ov_pkg::OT_LSRR,
                        ipv4ov_pkg::OT_SSRR,
                        ipv4ov_pkg::OT_RR:   ok = (word.option_byte >= ipv4ov_pkg::LEN_ROUTE);
                        default:             ok = (word.option_byte == ipv4ov_pkg::LEN_FIXED);
                    endcase
                    if (!ok)
                    begin
                        inv_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        left_next = word.option_byte - 8'd2;
                        off_next  = 8'd2;
                        ph_next   = (left_next == 8'd0) ? ipv4ov_pkg::PH_TYPE
                                                        : ipv4ov_pkg::PH_BODY;
                    end
                end
                default:
                begin
                    if (cur_reg == ipv4ov_pkg::OT_TS && off_reg == ipv4ov_pkg::TS_FLAG_OFS
                        && flg != ipv4ov_pkg::TS_FLG_ONLY && flg != ipv4ov_pkg::TS_FLG_ADDR
                        && flg != ipv4ov_pkg::TS_FLG_PRESP)
                    begin
                        inv_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        off_next  = off_reg + 8'd1;
                        left_next = left_reg - 8'd1;
                        if (left_next == 8'd0)
                        begin
                            ph_next = ipv4ov_pkg::PH_TYPE;
                        end
                    end
                end
            endcase
        end

        verdict = inv_next | (!done_next && ph_next != ipv4ov_pkg::PH_TYPE);

        if (word.last_byte)
        begin
            ph_next   = ipv4ov_pkg::PH_TYPE;
            cur_next  = ipv4ov_pkg::OT_SEC;
            left_next = 8'd0;
            off_next  = 8'd0;
            seen_next = '0;
            inv_next  = 1'b0;
            done_next = 1'b0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= ipv4ov_pkg::PH_TYPE;
            cur_reg  <= ipv4ov_pkg::OT_SEC;
            left_reg <= 8'd0;
            off_reg  <= 8'd0;
            seen_reg <= '0;
            inv_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (word.step)
        begin
            ph_reg   <= ph_next;
            cur_reg  <= cur_next;
            left_reg <= left_next;
            off_reg  <= off_next;
            seen_reg <= seen_next;
            inv_reg  <= inv_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ipv4_option_validator_core.sv
// Channel  Dir  Payload                  Word
// opt      in   option_byte[7:0], last   one option area byte
// res      out  verdict                  one verdict per area, on its last byte
//
// One word accepted per cycle while the walker is not held; the verdict passes from the
// input register through the option walker into the result register.
// rst_n clears the parse state and both valid flags; an area in progress is lost.
// A stalled result holds the walker only when the next word is a last byte.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_option_validator_core #(
    parameter int MAX_OPTION_BYTES = 40
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ipv4ov_in_if.sink    opt,
    ipv4ov_out_if.source res
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    logic       out_verdict_reg;
    logic       slot_free;
    logic       s1_adv;
    logic       verdict;

    ipv4ov_pkg::ipv4ov_word_t word;

    assign slot_free = !out_valid_reg || res.ready;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || slot_free);
    assign opt.ready = !s1_valid_reg || s1_adv;

    assign word.step        = s1_adv;
    assign word.option_byte = s1_byte_reg;
    assign word.last_byte   = s1_last_reg;

    ipv4ov_parse #(
        .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .word    (word),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (opt.ready)
            begin
                s1_valid_reg <= opt.valid;
            end
            if (s1_adv && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (opt.ready && opt.valid)
        begin
            s1_byte_reg <= opt.option_byte;
            s1_last_reg <= opt.last_byte;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_verdict_reg <= verdict;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.verdict = out_verdict_reg;

endmodule

`default_nettype wire

// File: verif/tb_ipv4_option_validator_core.sv
`timescale 1ns / 1ps

module tb_ipv4_option_validator_core;
    import ipv4ov_pkg::*;

    localparam int MAX_AREA    = 40;
    localparam int WORD_TARGET = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        logic verdict;
        int   area;
    } verdict_exp_t;

    logic clk;
    logic rst_n;

    ipv4ov_in_if  opt ();
    ipv4ov_out_if res ();

    ipv4_option_validator_core #(
        .MAX_OPTION_BYTES(MAX_AREA)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .opt  (opt),
        .res  (res)
    );

    // walker state
    logic [1:0] walk_phase;
    logic [2:0] walk_kind;
    logic [7:0] walk_body_left;
    logic [7:0] walk_pos;
    logic [4:0] walk_seen;
    logic       walk_bad;
    logic       walk_done;
    int         walk_count;

    verdict_exp_t pending_verdicts[$];
    logic [7:0]   area_bytes[$];

    int  errors        = 0;
    int  cycle_count   = 0;
    int  words_sent    = 0;
    int  areas_sent    = 0;
    int  verdicts_seen = 0;
    int  invalid_seen  = 0;
    int  input_stalls  = 0;
    int  hold_left     = 0;
    int  stall_left    = 0;
    bit  tx_gaps_on    = 1'b1;
    bit  rx_stalls_on  = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void clear_walker();
        walk_phase     = PH_TYPE;
        walk_kind      = OT_SEC;
        walk_body_left = '0;
        walk_pos       = '0;
        walk_seen      = '0;
        walk_bad       = 1'b0;
        walk_done      = 1'b0;
        walk_count     = 0;
    endfunction

    function automatic void walk_option_byte(input logic [7:0] b, input logic last);
        logic       known;
        logic       ok;
        logic [2:0] kind;
        logic [3:0] flg;
        verdict_exp_t e;
        known = 1'b0;
        ok    = 1'b0;
        kind  = OT_SEC;
        flg   = b[3:0];
        if (walk_count < 256)
            walk_count++;
        if (walk_count > MAX_AREA)
            walk_bad = 1'b1;
        if (!walk_done)
        begin
            if (walk_phase == PH_TYPE)
            begin
                known = 1'b1;
                case (b)
                    TYPE_EOL:
                    begin
                        walk_done = 1'b1;
                        known     = 1'b0;
                    end
                    TYPE_NOP:    known = 1'b0;
                    TYPE_SEC:    kind = OT_SEC;
                    TYPE_LSRR:   kind = OT_LSRR;
                    TYPE_SSRR:   kind = OT_SSRR;
                    TYPE_RR:     kind = OT_RR;
                    TYPE_TS:     kind = OT_TS;
                    TYPE_RTRALT: kind = OT_RTRALT;
                    default:
                    begin
                        walk_bad  = 1'b1;
                        walk_done = 1'b1;
                        known     = 1'b0;
                    end
                endcase
                if (known)
                begin
                    if (kind != OT_RTRALT && walk_seen[kind])
                    begin
                        walk_bad  = 1'b1;
                        walk_done = 1'b1;
                    end
                    else
                    begin
                        if (kind != OT_RTRALT)
                            walk_seen[kind] = 1'b1;
                        walk_kind  = kind;
                        walk_pos   = 8'd1;
                        walk_phase = PH_LEN;
                    end
                end
            end
            else if (walk_phase == PH_LEN)
            begin
                case (walk_kind)
                    OT_SEC:                  ok = (b == LEN_SEC);
                    OT_LSRR, OT_SSRR, OT_RR: ok = (b >= LEN_ROUTE);
                    default:                 ok = (b == LEN_FIXED);
                endcase
                if (!ok)
                begin
                    walk_bad  = 1'b1;
                    walk_done = 1'b1;
                end
                else
                begin
                    walk_body_left = b - 8'd2;
                    walk_pos       = 8'd2;
                    walk_phase     = (walk_body_left == 8'd0) ? PH_TYPE : PH_BODY;
                end
            end
            else
            begin
                if (walk_kind == OT_TS && walk_pos == TS_FLAG_OFS
                    && flg != TS_FLG_ONLY && flg != TS_FLG_ADDR && flg != TS_FLG_PRESP)
                begin
                    walk_bad  = 1'b1;
                    walk_done = 1'b1;
                end
                else
                begin
                    walk_pos       = walk_pos + 8'd1;
                    walk_body_left = walk_body_left - 8'd1;
                    if (walk_body_left == 8'd0)
                        walk_phase = PH_TYPE;
                end
            end
        end
        if (last)
        begin
            if (!walk_done && walk_phase != PH_TYPE)
                walk_bad = 1'b1;
            e.verdict = walk_bad;
            e.area    = areas_sent;
            pending_verdicts.push_back(e);
            areas_sent++;
            clear_walker();
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        opt.valid       <= 1'b1;
        opt.option_byte <= b;
        opt.last_byte   <= last;
        @(posedge clk);
        while (!opt.ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        walk_option_byte(b, last);
        words_sent++;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            opt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_area();
        for (int i = 0; i < area_bytes.size(); i++)
            send_word(area_bytes[i], i == area_bytes.size() - 1);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            area_bytes.push_back(8'($urandom));
    endtask

    task automatic build_random_area();
        int         target;
        int         len;
        logic [3:0] lo;
        area_bytes.delete();
        target = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
        while (area_bytes.size() < target)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    area_bytes.push_back(TYPE_EOL);
                    push_random(target - area_bytes.size());
                end
                1, 2: area_bytes.push_back(TYPE_NOP);
                3:
                begin
                    area_bytes.push_back(TYPE_SEC);
                    area_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : LEN_SEC);
                    push_random(9);
                end
                4, 5, 6:
                begin
                    case ($urandom_range(0, 2))
                        0: area_bytes.push_back(TYPE_LSRR);
                        1: area_bytes.push_back(TYPE_SSRR);
                        default: area_bytes.push_back(TYPE_RR);
                    endcase
                    case ($urandom_range(0, 19))
                        0: len = $urandom_range(0, 2);
                        1: len = $urandom_range(3, 255);
                        default: len = $urandom_range(3, 11);
                    endcase
                    area_bytes.push_back(8'(len));
                    if (len >= 3)
                        push_random((len - 2 > 20) ? 20 : len - 2);
                end
                7, 8:
                begin
                    area_bytes.push_back(TYPE_TS);
                    area_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : LEN_FIXED);
                    push_random(1);
                    case ($urandom_range(0, 3))
                        0: lo = TS_FLG_ONLY;
                        1: lo = TS_FLG_ADDR;
                        2: lo = TS_FLG_PRESP;
                        default: lo = 4'($urandom);
                    endcase
                    area_bytes.push_back({4'($urandom), lo});
                end
                9, 10:
                begin
                    area_bytes.push_back(TYPE_RTRALT);
                    area_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : LEN_FIXED);
                    push_random(2);
                end
                default: push_random(1);
            endcase
        end
        // truncation and corruption
        if (area_bytes.size() > 1 && $urandom_range(0, 9) == 0)
            void'(area_bytes.pop_back());
        if ($urandom_range(0, 14) == 0)
            area_bytes[$urandom_range(0, area_bytes.size() - 1)] = 8'($urandom);
    endtask

    task automatic test_directed();
        area_bytes = '{TYPE_EOL};
        send_area();
        area_bytes = '{TYPE_NOP};
        send_area();
        area_bytes = '{8'hff};
        send_area();
        area_bytes = '{TYPE_RTRALT};
        send_area();
        area_bytes = '{TYPE_RR, LEN_ROUTE, 8'haa};
        send_area();
        area_bytes = '{TYPE_RR, 8'd2};
        send_area();
        area_bytes = '{TYPE_TS, LEN_FIXED, 8'd5, 8'h2f};
        send_area();
        area_bytes = '{TYPE_TS, LEN_FIXED, 8'h00, 8'hf3};
        send_area();
        area_bytes = '{8'h63, TYPE_EOL};
        send_area();
        area_bytes = '{TYPE_SSRR, 8'd200};
        send_area();
    endtask

    task automatic test_area_length();
        area_bytes.delete();
        repeat (MAX_AREA) area_bytes.push_back(TYPE_NOP);
        send_area();
        area_bytes.push_back(TYPE_NOP);
        send_area();
        area_bytes = '{TYPE_EOL};
        repeat (MAX_AREA) area_bytes.push_back(8'h00);
        send_area();
        area_bytes.delete();
        repeat (300) area_bytes.push_back(TYPE_NOP);
        send_area();
    endtask

    task automatic test_back_to_back();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (15)
        begin
            build_random_area();
            send_area();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_left  = 150;
        for (int i = 0; i < 40; i++)
        begin
            area_bytes = '{(i % 2 == 0) ? TYPE_NOP : 8'hff};
            send_area();
        end
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        while (words_sent < WORD_TARGET)
        begin
            tx_gaps_on   = ($urandom_range(0, 7) != 0);
            rx_stalls_on = ($urandom_range(0, 7) != 0);
            build_random_area();
            send_area();
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // receiver: a long hold-off when one is set, otherwise random stalls
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_exp_t e;
        if (rst_n && res.valid && res.ready)
        begin
            verdicts_seen++;
            if (res.verdict)
                invalid_seen++;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected verdict %0b at cycle %0d", res.verdict, cycle_count);
            end
            else
            begin
                e = pending_verdicts.pop_front();
                if (res.verdict !== e.verdict)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("area %0d: verdict expected %0b, got %0b",
                                 e.area, e.verdict, res.verdict);
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        clk             = 1'b0;
        opt.valid       <= 1'b0;
        opt.option_byte <= '0;
        opt.last_byte   <= 1'b0;
        clear_walker();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_area_length();
        test_back_to_back();
        test_backpressure();
        test_random();

        opt.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d areas in %0d words; %0d verdicts checked, %0d invalid",
                 areas_sent, words_sent, verdicts_seen, invalid_seen);
        $display("%0d cycles of input stall, %0d mismatches", input_stalls, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
